@@ src/bms_pkg.sv @@
// ----------------------------------------------------------------------------
// bms_pkg
// Types and constants shared by the brace match scanner modules.
// ----------------------------------------------------------------------------
package bms_pkg;

  // Default widths of the depth counter and the byte offset counter.
  localparam int OFFSET_BITS_DEF = 24;
  localparam int DEPTH_BITS_DEF  = 16;

  // Width of the reported end offset field.
  localparam int END_OFFSET_W = 24;

  // Lexical modes, as reported in the lex_mode field.
  typedef enum logic [2:0] {
    MODE_CODE  = 3'd0,
    MODE_LINE  = 3'd1,
    MODE_BLOCK = 3'd2,
    MODE_STR   = 3'd3,
    MODE_CHR   = 3'd4
  } lex_mode_t;

  // Character codes the scanner reacts to.
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;

  // One input item: a byte, its lookahead and the search control bits.
  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] next_byte;
    logic       next_present;
    logic       first;
  } item_t;

  // One result item.
  typedef struct packed {
    logic                    found;
    logic                    unmatched;
    logic [END_OFFSET_W-1:0] end_offset;
    logic [2:0]              lex_mode;
  } result_t;

endpackage

@@ src/bms_step.sv @@
// ----------------------------------------------------------------------------
// bms_step
// Combinational update of the scanner state for one byte.
// ----------------------------------------------------------------------------
module bms_step #(
  parameter int OFFSET_BITS = bms_pkg::OFFSET_BITS_DEF,
  parameter int DEPTH_BITS  = bms_pkg::DEPTH_BITS_DEF
) (
  input  bms_pkg::item_t                item,
  input  bms_pkg::lex_mode_t            mode,
  input  logic [7:0]                    prev,
  input  logic signed [DEPTH_BITS-1:0]  depth,
  input  logic [OFFSET_BITS-1:0]        offset,
  input  logic                          done,
  output bms_pkg::result_t              res,
  output bms_pkg::lex_mode_t            mode_next,
  output logic [7:0]                    prev_next,
  output logic signed [DEPTH_BITS-1:0]  depth_next,
  output logic [OFFSET_BITS-1:0]        offset_next,
  output logic                          done_next
);

  localparam logic signed [DEPTH_BITS-1:0] DepMax = {1'b0, {(DEPTH_BITS-1){1'b1}}};
  localparam logic signed [DEPTH_BITS-1:0] DepMin = {1'b1, {(DEPTH_BITS-1){1'b0}}};
  localparam logic [OFFSET_BITS-1:0]       OffMax = {OFFSET_BITS{1'b1}};

  bms_pkg::lex_mode_t           eff_mode;
  bms_pkg::lex_mode_t           new_mode;
  logic [7:0]                   eff_prev;
  logic signed [DEPTH_BITS-1:0] eff_depth;
  logic signed [DEPTH_BITS-1:0] new_depth;
  logic [OFFSET_BITS-1:0]       eff_offset;
  logic [OFFSET_BITS-1:0]       new_offset;
  logic                         eff_done;
  logic                         hit;
  logic                         miss;
  logic [7:0]                   c;
  logic                         slash_next;
  logic                         star_next;

  always_comb begin
    // A first byte restarts the search from a cleared state.
    eff_mode   = item.first ? bms_pkg::MODE_CODE : mode;
    eff_prev   = item.first ? 8'h00 : prev;
    eff_depth  = item.first ? '0 : depth;
    eff_offset = item.first ? '0 : offset;
    eff_done   = item.first ? 1'b0 : done;

    c          = item.data_byte;
    slash_next = item.next_present && (item.next_byte == bms_pkg::CH_SLASH);
    star_next  = item.next_present && (item.next_byte == bms_pkg::CH_STAR);

    new_mode  = eff_mode;
    new_depth = eff_depth;
    hit       = 1'b0;

    case (eff_mode)
      bms_pkg::MODE_LINE: begin
        if (c == bms_pkg::CH_NL) new_mode = bms_pkg::MODE_CODE;
      end
      bms_pkg::MODE_BLOCK: begin
        if (c == bms_pkg::CH_SLASH && eff_prev == bms_pkg::CH_STAR)
          new_mode = bms_pkg::MODE_CODE;
      end
      bms_pkg::MODE_STR: begin
        if (c == bms_pkg::CH_DQUOTE && eff_prev != bms_pkg::CH_BSLASH)
          new_mode = bms_pkg::MODE_CODE;
      end
      bms_pkg::MODE_CHR: begin
        if (c == bms_pkg::CH_SQUOTE && eff_prev != bms_pkg::CH_BSLASH)
          new_mode = bms_pkg::MODE_CODE;
      end
      default: begin
        if (c == bms_pkg::CH_SLASH && slash_next) begin
          new_mode = bms_pkg::MODE_LINE;
        end else if (c == bms_pkg::CH_SLASH && star_next) begin
          new_mode = bms_pkg::MODE_BLOCK;
        end else if (c == bms_pkg::CH_DQUOTE) begin
          new_mode = bms_pkg::MODE_STR;
        end else if (c == bms_pkg::CH_SQUOTE) begin
          new_mode = bms_pkg::MODE_CHR;
        end else if (c == bms_pkg::CH_LBRACE) begin
          if (eff_depth != DepMax) new_depth = eff_depth + DEPTH_BITS'(1);
        end else if (c == bms_pkg::CH_RBRACE) begin
          if (eff_depth != DepMin) new_depth = eff_depth - DEPTH_BITS'(1);
          hit = (new_depth == '0);
        end
      end
    endcase

    new_offset = (eff_offset != OffMax) ? eff_offset + OFFSET_BITS'(1) : eff_offset;
    miss       = !hit && !item.next_present;

    if (eff_done) begin
      // A finished search holds its state until the next first byte.
      mode_next   = eff_mode;
      prev_next   = eff_prev;
      depth_next  = eff_depth;
      offset_next = eff_offset;
      done_next   = 1'b1;
      res.found      = 1'b0;
      res.unmatched  = 1'b0;
      res.end_offset = '0;
      res.lex_mode   = eff_mode;
    end else begin
      mode_next   = new_mode;
      prev_next   = c;
      depth_next  = new_depth;
      offset_next = new_offset;
      done_next   = hit || miss;
      res.found      = hit;
      res.unmatched  = miss;
      res.end_offset = hit ? bms_pkg::END_OFFSET_W'(new_offset) : '0;
      res.lex_mode   = new_mode;
    end
  end

endmodule

@@ src/brace_match_scanner.sv @@
// ----------------------------------------------------------------------------
// brace_match_scanner
// Finds the brace that closes the first nesting level of a byte stream.
// ----------------------------------------------------------------------------
// Usage: each transfer on the item channel carries one source byte, the byte
// after it as lookahead (next_present low marks the final byte) and a first
// flag that starts a new search at that byte. Every item yields exactly one
// transfer on the res channel, in order. The result says whether this byte
// is the brace that brings the depth back to zero (found, with the offset
// just past it), whether the stream ended without a match (unmatched), and
// the lexical mode after the byte. Once a search has finished, further bytes
// without first give empty results until the next first byte.
// Each item is held in the input register and then in the result register
// before its result can transfer. While res_stall stays low the scanner
// takes one item per cycle, as the mode, depth and offset update that feeds
// the state registers back to themselves is combinational.
// Reset clears the pipeline and the scanner state, so the first byte after
// reset behaves as if first were set. When res_stall is high the result
// register holds, the input register fills, and item_stall rises only once
// both stages are occupied.
// ----------------------------------------------------------------------------
module brace_match_scanner #(
  parameter int OFFSET_BITS = bms_pkg::OFFSET_BITS_DEF,
  parameter int DEPTH_BITS  = bms_pkg::DEPTH_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  bms_pkg::item_t   item,
  output logic             res_valid,
  input  logic             res_stall,
  output bms_pkg::result_t res
);

  // Input register stage.
  logic           in_full;
  bms_pkg::item_t in_q;

  // Scanner state, updated when an item moves into the result register.
  bms_pkg::lex_mode_t           mode;
  logic [7:0]                   prev;
  logic signed [DEPTH_BITS-1:0] depth;
  logic [OFFSET_BITS-1:0]       offset;
  logic                         done;

  bms_pkg::lex_mode_t           mode_next;
  logic [7:0]                   prev_next;
  logic signed [DEPTH_BITS-1:0] depth_next;
  logic [OFFSET_BITS-1:0]       offset_next;
  logic                         done_next;
  bms_pkg::result_t             step_res;

  logic advance;
  logic take;

  // The held item moves on whenever the result register is empty or is
  // being emptied in this cycle.
  assign advance    = in_full && (!res_valid || !res_stall);
  assign item_stall = in_full && !advance;
  assign take       = item_valid && !item_stall;

  bms_step #(
    .OFFSET_BITS (OFFSET_BITS),
    .DEPTH_BITS  (DEPTH_BITS)
  ) u_step (
    .item        (in_q),
    .mode        (mode),
    .prev        (prev),
    .depth       (depth),
    .offset      (offset),
    .done        (done),
    .res         (step_res),
    .mode_next   (mode_next),
    .prev_next   (prev_next),
    .depth_next  (depth_next),
    .offset_next (offset_next),
    .done_next   (done_next)
  );

  // Control: stage occupancy and scanner state.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      res_valid <= 1'b0;
      mode      <= bms_pkg::MODE_CODE;
      prev      <= 8'h00;
      depth     <= '0;
      offset    <= '0;
      done      <= 1'b0;
    end else begin
      if (take) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end

      if (advance) begin
        res_valid <= 1'b1;
        mode      <= mode_next;
        prev      <= prev_next;
        depth     <= depth_next;
        offset    <= offset_next;
        done      <= done_next;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (take) begin
      in_q <= item;
    end
    if (advance) begin
      res <= step_res;
    end
  end

`ifndef SYNTH
  // A result never reports both a match and an unmatched end.
  a_found_excl: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.found && res.unmatched))
    else $error("found and unmatched both set");

  // The end offset is only nonzero alongside a match.
  a_offset_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.found) |-> (res.end_offset == '0))
    else $error("end_offset set without found");

  // A reported match or end of stream closes the search.
  a_done_after: assert property (@(posedge clk) disable iff (rst)
    (advance && (step_res.found || step_res.unmatched)) |=> done)
    else $error("search not closed after a final result");

  // The input side is held back only while both stages are occupied.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (in_full && res_valid && res_stall))
    else $error("item_stall without a full pipeline");

  // A stalled result register keeps its contents.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(res)))
    else $error("result changed while stalled");
`endif

endmodule
